>>> hw/rtl/prpm_pkg.sv
// Shared types and constants of the pulse-rate power meter.
package prpm_pkg;

  localparam int unsigned DIV_W      = 32;
  localparam int unsigned CNT_W      = $clog2(DIV_W);
  localparam int unsigned RUN_W      = 4;
  localparam int unsigned ITVL_W     = 23;
  localparam int unsigned PWR_W      = 16;

  localparam logic [RUN_W-1:0] RUN_MAX   = 4'd15;
  localparam logic [DIV_W-1:0] US_PER_MS = 32'd1000;
  localparam logic [PWR_W-1:0] PWR_SAT   = 16'hFFFF;

  localparam logic [7:0]        THRESHOLD_RST  = 8'd50;
  localparam logic [3:0]        OVERSAMPLE_RST = 4'd2;
  localparam logic [ITVL_W-1:0] TIMEOUT_RST    = 23'd300000;
  localparam logic [31:0]       CONSTANT_RST   = 32'd48000000;

  typedef enum logic [1:0] {
    CFG_THRESHOLD  = 2'd0,
    CFG_OVERSAMPLE = 2'd1,
    CFG_TIMEOUT    = 2'd2,
    CFG_CONSTANT   = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [7:0]        threshold;
    logic [3:0]        oversample;
    logic [ITVL_W-1:0] timeout_ms;
    logic [31:0]       constant;
  } cfg_t;

  typedef struct packed {
    logic             start;
    logic [DIV_W-1:0] dividend;
    logic [DIV_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [DIV_W-1:0] quotient;
  } div_rsp_t;

endpackage

>>> hw/rtl/prpm_cfg.sv
// Configuration register file of the pulse-rate power meter.
module prpm_cfg import prpm_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       we_i,
  input  cfg_idx_e   index_i,
  input  logic [31:0] data_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (we_i) begin
      case (index_i)
        CFG_THRESHOLD:  cfg_d.threshold  = data_i[7:0];
        CFG_OVERSAMPLE: cfg_d.oversample = data_i[3:0];
        CFG_TIMEOUT:    cfg_d.timeout_ms = data_i[ITVL_W-1:0];
        CFG_CONSTANT:   cfg_d.constant   = data_i;
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.threshold  <= THRESHOLD_RST;
      cfg_q.oversample <= OVERSAMPLE_RST;
      cfg_q.timeout_ms <= TIMEOUT_RST;
      cfg_q.constant   <= CONSTANT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hw/rtl/prpm_sdiv.sv
// Bit-serial restoring divider, one quotient bit per cycle.
module prpm_sdiv import prpm_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  div_req_t req_i,
  output div_rsp_t rsp_o
);

  localparam logic [CNT_W-1:0] LastStep = CNT_W'(DIV_W - 1);

  logic             busy_q, done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DIV_W-1:0] rem_q, quo_q, dsr_q;
  logic [DIV_W:0]   trial, diff;
  logic             fits;

  // The partial remainder takes the next dividend bit, then the divisor is
  // subtracted whenever it fits.
  always_comb begin
    trial = {rem_q, quo_q[DIV_W-1]};
    fits  = trial >= {1'b0, dsr_q};
    diff  = trial - {1'b0, dsr_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= '0;
      dsr_q  <= '0;
    end else if (req_i.start) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quo_q  <= req_i.dividend;
      dsr_q  <= req_i.divisor;
    end else if (busy_q) begin
      rem_q <= fits ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      quo_q <= {quo_q[DIV_W-2:0], fits};
      cnt_q <= cnt_q + CNT_W'(1);
      if (cnt_q == LastStep) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;

endmodule

>>> hw/rtl/pulse_rate_power_meter.sv
// Top level of the pulse-rate power meter: sample handling, sequencing and the result register.
//
//   Channel  Direction  Handshake                  Payload
//   in       to block   in_valid_i / in_stall_o    sample_i, time_us_i
//   out      from block out_valid_o / out_stall_i  sequence_res_o, pulse_count_o,
//                                                  power_watts_o, updated_o, above_o
//   cfg      to block   cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// A sample beat runs once through the single bit-serial divider for the interval in
// milliseconds and, on a meter pulse with a nonzero interval, once more for the power
// quotient. A new sample is stalled until the beat is committed.
// Reset is asynchronous and active low; it restores the register defaults and clears the
// run, the counters, the power value and the recorded pulse time.
// A stalled output beat holds its payload; the next sample is still taken and worked on,
// and only its final commit waits until the output register is free.
module pulse_rate_power_meter import prpm_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // sample channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  sample_i,
  input  logic [31:0] time_us_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] sequence_res_o,
  output logic [15:0] pulse_count_o,
  output logic [15:0] power_watts_o,
  output logic        updated_o,
  output logic        above_o,
  // configuration channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MS,
    ST_PWR,
    ST_COMMIT
  } state_e;

  state_e            state_q;
  cfg_t              cfg;
  div_req_t          div_req_q;
  div_rsp_t          div_rsp;

  logic [RUN_W-1:0]  run_q;
  logic [31:0]       last_q;
  logic [15:0]       seq_q, pcnt_q, power_q;
  logic [31:0]       now_q;
  logic              pulse_q, above_q;
  logic [ITVL_W-1:0] itvl_q;
  logic [PWR_W-1:0]  pwr_q;
  logic              out_valid_q, updated_q, out_above_q;
  logic [15:0]       out_seq_q, out_pcnt_q, out_power_q;

  logic              in_acc, commit_go, timed_out;
  logic              above, pulse;
  logic [RUN_W:0]    run_next;

  // The registers are always ready; the user's writes must arrive only while idle, unenforced.
  assign cfg_ready_o = 1'b1;

  prpm_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_valid_i),
    .index_i (cfg_idx_e'(cfg_index_i)),
    .data_i  (cfg_data_i),
    .cfg_o   (cfg)
  );

  prpm_sdiv u_sdiv (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req_q),
    .rsp_o  (div_rsp)
  );

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;

  // A bright sample extends the run; the pulse fires only on the step where the run
  // grows to equal the oversample count, so a long bright stretch yields one pulse.
  always_comb begin
    above    = sample_i > cfg.threshold;
    run_next = {1'b0, run_q} + (RUN_W+1)'(1);
    pulse    = above && (run_next == {1'b0, cfg.oversample});
  end

  // The record is committed only once the output register can take a new beat.
  assign commit_go = (state_q == ST_COMMIT) && (!out_valid_q || !out_stall_i);
  assign timed_out = (itvl_q > cfg.timeout_ms) && (power_q != '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      div_req_q   <= '0;
      run_q       <= '0;
      last_q      <= '0;
      seq_q       <= '0;
      pcnt_q      <= '0;
      power_q     <= '0;
      now_q       <= '0;
      pulse_q     <= 1'b0;
      above_q     <= 1'b0;
      itvl_q      <= '0;
      pwr_q       <= '0;
      out_valid_q <= 1'b0;
      updated_q   <= 1'b0;
      out_above_q <= 1'b0;
      out_seq_q   <= '0;
      out_pcnt_q  <= '0;
      out_power_q <= '0;
    end else begin
      // The start strobe lasts one cycle; it is never raised again in the cycle it drops.
      if (div_req_q.start) begin
        div_req_q.start <= 1'b0;
      end
      if (out_valid_q && !out_stall_i && !commit_go) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            above_q <= above;
            pulse_q <= pulse;
            now_q   <= time_us_i;
            if (!above) begin
              run_q <= '0;
            end else if (run_next > {1'b0, RUN_MAX}) begin
              run_q <= RUN_MAX;
            end else begin
              run_q <= run_next[RUN_W-1:0];
            end
            // First pass: elapsed microseconds, modulo 2^32, down to whole milliseconds.
            div_req_q.start    <= 1'b1;
            div_req_q.dividend <= time_us_i - last_q;
            div_req_q.divisor  <= US_PER_MS;
            state_q            <= ST_MS;
          end
        end
        ST_MS: begin
          if (div_rsp.done) begin
            itvl_q <= div_rsp.quotient[ITVL_W-1:0];
            // A zero interval reads as the largest power the record can hold.
            pwr_q  <= PWR_SAT;
            if (pulse_q && (div_rsp.quotient != '0)) begin
              div_req_q.start    <= 1'b1;
              div_req_q.dividend <= cfg.constant;
              div_req_q.divisor  <= div_rsp.quotient;
              state_q            <= ST_PWR;
            end else begin
              state_q <= ST_COMMIT;
            end
          end
        end
        ST_PWR: begin
          if (div_rsp.done) begin
            if (div_rsp.quotient[DIV_W-1:PWR_W] != '0) begin
              pwr_q <= PWR_SAT;
            end else begin
              pwr_q <= div_rsp.quotient[PWR_W-1:0];
            end
            state_q <= ST_COMMIT;
          end
        end
        ST_COMMIT: begin
          if (commit_go) begin
            out_valid_q <= 1'b1;
            out_above_q <= above_q;
            if (pulse_q) begin
              seq_q       <= seq_q + 16'd1;
              pcnt_q      <= pcnt_q + 16'd1;
              last_q      <= now_q;
              power_q     <= pwr_q;
              out_seq_q   <= seq_q + 16'd1;
              out_pcnt_q  <= pcnt_q + 16'd1;
              out_power_q <= pwr_q;
              updated_q   <= 1'b1;
            end else if (timed_out) begin
              seq_q       <= seq_q + 16'd1;
              power_q     <= '0;
              out_seq_q   <= seq_q + 16'd1;
              out_pcnt_q  <= pcnt_q;
              out_power_q <= '0;
              updated_q   <= 1'b1;
            end else begin
              out_seq_q   <= seq_q;
              out_pcnt_q  <= pcnt_q;
              out_power_q <= power_q;
              updated_q   <= 1'b0;
            end
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sequence_res_o = out_seq_q;
  assign pulse_count_o  = out_pcnt_q;
  assign power_watts_o  = out_power_q;
  assign updated_o      = updated_q;
  assign above_o        = out_above_q;

`ifndef ASSERT_OFF
  // A new result beat only appears out of the commit step.
  a_beat_from_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_COMMIT))
    else $error("result beat raised outside commit");

  // An accepted sample always starts the millisecond division.
  a_accept_starts_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> (state_q == ST_MS) && div_req_q.start)
    else $error("accepted sample did not start the divider");

  // A committed pulse advances the pulse counter by exactly one.
  a_pulse_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (commit_go && pulse_q) |=> (pcnt_q == $past(pcnt_q) + 16'd1) && updated_q)
    else $error("pulse commit did not advance the pulse count");

  // The result register is never overwritten while its beat is stalled.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit_go |-> (!out_valid_q || !out_stall_i))
    else $error("commit while result beat was stalled");
`endif

endmodule

>>> dv/pulse_rate_power_meter_test.sv
`timescale 1ns / 1ps
// Self-checking testbench of the pulse-rate power meter: directed and random beats vs a predictor.
module pulse_rate_power_meter_test;
  import prpm_pkg::*;

  // One sample beat as offered on the input channel.
  typedef struct packed {
    logic [7:0]  sample;
    logic [31:0] time_us;
  } meter_beat_t;

  // One meter record as returned on the result channel.
  typedef struct packed {
    logic [15:0] sequence_res;
    logic [15:0] pulse_count;
    logic [15:0] power_watts;
    logic        updated;
    logic        above;
  } meter_record_t;

  // Every input is given a known value from time zero.
  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic [7:0]  sample_i    = '0;
  logic [31:0] time_us_i   = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [15:0] sequence_res_o;
  logic [15:0] pulse_count_o;
  logic [15:0] power_watts_o;
  logic        updated_o;
  logic        above_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_index_i = CFG_THRESHOLD;
  logic [31:0] cfg_data_i  = '0;

  pulse_rate_power_meter dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .sample_i       (sample_i),
    .time_us_i      (time_us_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sequence_res_o (sequence_res_o),
    .pulse_count_o  (pulse_count_o),
    .power_watts_o  (power_watts_o),
    .updated_o      (updated_o),
    .above_o        (above_o),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Shadow copy of the register file. It is only changed while the block is idle, so the
  // predictor always sees the same settings as the block did for the beat in question.
  logic [7:0]        thr_q   = THRESHOLD_RST;
  logic [3:0]        os_q    = OVERSAMPLE_RST;
  logic [ITVL_W-1:0] tmo_q   = TIMEOUT_RST;
  logic [31:0]       const_q = CONSTANT_RST;

  // Predicted meter state. Reset is applied once at the start, so the declared values hold.
  logic [RUN_W-1:0] run_q         = '0;
  logic [31:0]      last_pulse_us = '0;
  logic [15:0]      seq_q         = '0;
  logic [15:0]      pulses_q      = '0;
  logic [15:0]      power_q       = '0;

  meter_beat_t   sample_beats[$];
  meter_record_t expected_records[$];

  int unsigned mismatches = 0;
  int unsigned in_gap     = 0;
  int unsigned out_wait   = 0;
  int unsigned hold_left  = 0;
  int unsigned bright_left = 0;
  logic [31:0] clock_us   = '0;
  bit          quiet_in   = 1'b0;
  bit          quiet_out  = 1'b0;
  bit          hold_req   = 1'b0;

  // Works out the record that one sample beat leaves behind and advances the predicted state.
  function automatic meter_record_t predict_record(logic [7:0] smp, logic [31:0] now);
    meter_record_t rec;
    logic [RUN_W:0] grown;
    logic [31:0]    itvl_ms;
    logic [31:0]    quot;
    logic           hit;
    rec = '0;
    hit = 1'b0;
    rec.above = smp > thr_q;
    // A pulse is counted only on the beat where the bright run grows to the oversample
    // count; the run saturates at RUN_MAX, so a long bright stretch yields a single pulse.
    if (rec.above) begin
      grown = {1'b0, run_q} + 5'd1;
      hit = (grown == {1'b0, os_q});
      run_q = (grown > {1'b0, RUN_MAX}) ? RUN_MAX : grown[RUN_W-1:0];
    end else begin
      run_q = '0;
    end
    // The subtraction wraps with the free-running microsecond counter.
    itvl_ms = (now - last_pulse_us) / US_PER_MS;
    if (hit) begin
      if (itvl_ms == 0) begin
        quot = PWR_SAT;
      end else begin
        quot = const_q / itvl_ms;
      end
      if (quot > PWR_SAT) begin
        quot = PWR_SAT;
      end
      seq_q++;
      pulses_q++;
      last_pulse_us = now;
      power_q = quot[PWR_W-1:0];
      rec.updated = 1'b1;
    end else if (itvl_ms > tmo_q && power_q != 0) begin
      // Timeout: power is dropped to zero once, and only while it is still nonzero.
      seq_q++;
      power_q = '0;
      rec.updated = 1'b1;
    end
    rec.sequence_res = seq_q;
    rec.pulse_count  = pulses_q;
    rec.power_watts  = power_q;
    return rec;
  endfunction

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  // Sample driver. A beat that is stalled keeps its payload; the predictor runs at the edge
  // where the beat is taken, and a fresh idle gap is drawn for the next beat.
  always @(posedge clk_i or negedge rst_ni) begin
    meter_beat_t nxt;
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      if (in_valid_i && !in_stall_o) begin
        expected_records.push_back(predict_record(sample_i, time_us_i));
        in_gap = quiet_in ? 0 : $urandom_range(7, 0);
      end
      if (!in_valid_i || !in_stall_o) begin
        if (in_gap != 0) begin
          in_gap--;
          in_valid_i <= 1'b0;
        end else if (sample_beats.size() != 0) begin
          nxt = sample_beats.pop_front();
          in_valid_i <= 1'b1;
          sample_i   <= nxt.sample;
          time_us_i  <= nxt.time_us;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result monitor. Each taken beat is checked against the oldest expectation. The stall
  // is drawn per result; a long hold-off, when requested, is counted down here so that the
  // block fills up and has to stall its own input.
  always @(posedge clk_i or negedge rst_ni) begin
    meter_record_t want;
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        if (expected_records.size() == 0) begin
          mismatches++;
          $display("%0t: result beat with no expectation, expected none, actual seq %0d",
                   $time, sequence_res_o);
        end else begin
          want = expected_records.pop_front();
          compare_field("sequence_res", want.sequence_res, sequence_res_o);
          compare_field("pulse_count", want.pulse_count, pulse_count_o);
          compare_field("power_watts", want.power_watts, power_watts_o);
          compare_field("updated", {15'd0, want.updated}, {15'd0, updated_o});
          compare_field("above", {15'd0, want.above}, {15'd0, above_o});
        end
        out_wait = quiet_out ? 0 : $urandom_range(7, 0);
      end
      if (hold_req) begin
        hold_left = 400;
        hold_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (out_wait != 0) begin
        out_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic add_beat(logic [7:0] smp, logic [31:0] now);
    sample_beats.push_back('{sample: smp, time_us: now});
  endtask

  // Waits until every queued beat has gone in and every record has come back, then gives
  // the block time to settle before anything is reconfigured. The check is made at the
  // falling edge, once everything driven at the rising edge has settled.
  task automatic wait_idle();
    do @(negedge clk_i);
    while (sample_beats.size() != 0 || in_valid_i || expected_records.size() != 0);
    repeat (80) @(posedge clk_i);
  endtask

  // Writes one register over the configuration channel and mirrors it in the shadow copy.
  // The unused upper bits of the data word carry random junk, which the block must ignore.
  task automatic write_reg(cfg_idx_e idx, logic [31:0] value);
    logic [31:0] word;
    word = $urandom();
    case (idx)
      CFG_THRESHOLD:  word[7:0] = value[7:0];
      CFG_OVERSAMPLE: word[3:0] = value[3:0];
      CFG_TIMEOUT:    word[ITVL_W-1:0] = value[ITVL_W-1:0];
      default:        word = value;
    endcase
    @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= word;
    do @(posedge clk_i);
    while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      CFG_THRESHOLD:  thr_q = word[7:0];
      CFG_OVERSAMPLE: os_q = word[3:0];
      CFG_TIMEOUT:    tmo_q = word[ITVL_W-1:0];
      default:        const_q = word;
    endcase
  endtask

  task automatic write_settings(logic [7:0] thr, logic [3:0] os, logic [ITVL_W-1:0] tmo,
                                logic [31:0] pconst);
    write_reg(CFG_THRESHOLD, {24'd0, thr});
    write_reg(CFG_OVERSAMPLE, {28'd0, os});
    write_reg(CFG_TIMEOUT, {9'd0, tmo});
    write_reg(CFG_CONSTANT, pconst);
  endtask

  // Mostly well-formed light traces: bright runs of around the oversample length separated
  // by dark samples, with a steadily advancing clock. One beat in ten is pure noise.
  task automatic random_items(int count);
    meter_beat_t b;
    int unsigned pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(9, 0);
      if (pick == 0) begin
        b.sample  = 8'($urandom());
        b.time_us = $urandom();
      end else begin
        if (bright_left != 0) begin
          b.sample = (thr_q == 8'd255) ? 8'd255 : 8'($urandom_range(255, thr_q + 1));
          bright_left--;
        end else begin
          b.sample = 8'($urandom_range(thr_q, 0));
          bright_left = $urandom_range(os_q + 2, 0);
        end
        pick = $urandom_range(9, 0);
        if (pick < 2) begin
          clock_us += $urandom_range(999, 0);
        end else if (pick < 9) begin
          clock_us += $urandom_range(2_000_000, 0);
        end else begin
          clock_us += $urandom();
        end
        b.time_us = clock_us;
      end
      sample_beats.push_back(b);
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed beats at the reset settings (threshold 50, oversample 2).
    add_beat(8'd0, 32'd0);
    add_beat(8'd50, 32'd100);             // equal to the threshold is still dark
    add_beat(8'd51, 32'd1000);
    add_beat(8'd255, 32'd1500);           // pulse after 1 ms: the quotient saturates
    add_beat(8'd255, 32'd1800);           // run carries on, no second pulse
    add_beat(8'd0, 32'd2000);
    add_beat(8'd200, 32'd2100);
    add_beat(8'd200, 32'd2400);           // pulse under 1 ms after the last: zero interval
    add_beat(8'd0, 32'd3000);
    add_beat(8'd100, 32'd1_000_000);
    add_beat(8'd100, 32'd1_002_400);      // one second interval: 48 kW
    add_beat(8'd0, 32'd301_003_400);      // just past the timeout: power is cleared
    add_beat(8'd0, 32'd302_000_000);      // already zero, nothing changes
    add_beat(8'd255, 32'hFFFF_FFF0);
    add_beat(8'd255, 32'h0000_0100);      // interval taken across the counter wrap
    add_beat(8'd0, 32'hFFFF_FFFF);
    add_beat(8'd255, 32'd0);
    add_beat(8'd255, 32'd5);
    add_beat(8'd0, 32'd300_000_999);      // exactly at the timeout: kept
    add_beat(8'd0, 32'd300_001_005);      // one millisecond over: cleared
    wait_idle();

    // Long hold-off on the result side while the sender keeps offering beats.
    clock_us = 32'd400_000_000;
    random_items(60);
    hold_req = 1'b1;
    wait_idle();

    for (int ph = 0; ph < 9; ph++) begin
      case (ph)
        0: write_settings(8'd0, 4'd1, '0, '0);
        1: write_settings(8'd255, 4'd15, 23'd4294967, 32'hFFFF_FFFF);
        2: write_settings(8'd10, 4'd15, 23'd4294967, 32'hFFFF_FFFF);
        3: write_settings(8'd100, 4'd0, 23'd1000, 32'd48_000_000);
        default: write_settings(8'($urandom_range(200, 0)), 4'($urandom_range(4, 1)),
                                ITVL_W'($urandom_range(3000, 0)), $urandom());
      endcase
      // Some phases run back to back with no gaps on one side or both.
      quiet_in  = ($urandom_range(3, 0) == 0);
      quiet_out = ($urandom_range(3, 0) == 0);
      random_items(125);
      wait_idle();
    end

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule

>>> filelist.f
hw/rtl/prpm_pkg.sv
hw/rtl/prpm_cfg.sv
hw/rtl/prpm_sdiv.sv
hw/rtl/pulse_rate_power_meter.sv
dv/pulse_rate_power_meter_test.sv
